[rtl/mqms_pkg.sv]
`timescale 1ns / 1ps

package mqms_pkg;

    localparam int LINGER_BITS_DEF = 24;
    localparam int CFG_ADDR_W      = 5;
    localparam int CFG_DATA_W      = 32;
    localparam int LINGER_REG_W    = 24;
    localparam int SETTLE_W        = 16;

    localparam logic [SETTLE_W-1:0]     SETTLE_DRIVE_RST = 16'd2000;
    localparam logic [SETTLE_W-1:0]     SETTLE_HOME_RST  = 16'd5000;
    localparam logic [LINGER_REG_W-1:0] LINGER_RST       = 24'd0;

    typedef enum logic [2:0] {
        MS_INIT       = 3'd0,
        MS_WAIT_DRIVE = 3'd1,
        MS_WAIT_HOME  = 3'd2,
        MS_DRIVE      = 3'd3,
        MS_LINGER     = 3'd4,
        MS_HOME       = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        EV_NONE          = 3'd0,
        EV_ENTER_DRIVE   = 3'd1,
        EV_ENTER_HOME    = 3'd2,
        EV_LEAVE_HOME    = 3'd3,
        EV_DRIVE_TO_HOME = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        MOTION_INVALID    = 2'd0,
        MOTION_STATIONARY = 2'd1,
        MOTION_ACTIVE     = 2'd2
    } motion_t;

    typedef enum logic [1:0] {
        LINK_NONE = 2'd0,
        LINK_BLE  = 2'd1,
        LINK_WIFI = 2'd2
    } link_t;

    typedef enum logic [2:0] {
        REG_SETTLE_DRIVE = 3'd0,
        REG_SETTLE_HOME  = 3'd1,
        REG_LINGER       = 3'd2,
        REG_DRIVE_LINK   = 3'd3,
        REG_CLR_AUTOPID  = 3'd4,
        REG_SET_AUTOPID  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [SETTLE_W-1:0]     settle_drive;
        logic [SETTLE_W-1:0]     settle_home;
        logic [LINGER_REG_W-1:0] linger;
        logic [1:0]              link;
        logic                    clr_autopid;
        logic                    set_autopid;
    } cfg_t;

    typedef struct packed {
        logic [2:0] mode;
        logic       drive;
        logic       home;
        logic       autopid;
        logic [2:0] ev;
    } res_t;

endpackage

[rtl/mqms_cfg.sv]
`timescale 1ns / 1ps

module mqms_cfg
    import mqms_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SETTLE_DRIVE: cfg_next.settle_drive = pwdata[SETTLE_W-1:0];
                REG_SETTLE_HOME:  cfg_next.settle_home  = pwdata[SETTLE_W-1:0];
                REG_LINGER:       cfg_next.linger       = pwdata[LINGER_REG_W-1:0];
                REG_DRIVE_LINK:   cfg_next.link         = pwdata[1:0];
                REG_CLR_AUTOPID:  cfg_next.clr_autopid  = pwdata[0];
                REG_SET_AUTOPID:  cfg_next.set_autopid  = pwdata[0];
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SETTLE_DRIVE: prdata = CFG_DATA_W'(cfg_reg.settle_drive);
            REG_SETTLE_HOME:  prdata = CFG_DATA_W'(cfg_reg.settle_home);
            REG_LINGER:       prdata = CFG_DATA_W'(cfg_reg.linger);
            REG_DRIVE_LINK:   prdata = CFG_DATA_W'(cfg_reg.link);
            REG_CLR_AUTOPID:  prdata = CFG_DATA_W'(cfg_reg.clr_autopid);
            REG_SET_AUTOPID:  prdata = CFG_DATA_W'(cfg_reg.set_autopid);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_drive <= SETTLE_DRIVE_RST;
            cfg_reg.settle_home  <= SETTLE_HOME_RST;
            cfg_reg.linger       <= LINGER_RST;
            cfg_reg.link         <= LINK_NONE;
            cfg_reg.clr_autopid  <= 1'b0;
            cfg_reg.set_autopid  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/mqms_fsm.sv]
`timescale 1ns / 1ps

module mqms_fsm
    import mqms_pkg::*;
#(
    parameter int LINGER_BITS = LINGER_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick,
    input  logic [1:0] motion,
    input  logic       ble,
    input  cfg_t       cfg,
    output res_t       res
);

    localparam logic [31:0] LINGER_MAX = 32'((64'd1 << LINGER_BITS) - 64'd1);

    mode_t                  mode_reg, mode_next;
    logic [SETTLE_W-1:0]    settle_reg, settle_next, settle_dec;
    logic [LINGER_BITS-1:0] linger_reg, linger_next, linger_dec;
    logic                   drive_reg, drive_next;
    logic                   home_reg, home_next;
    logic                   autopid_reg, autopid_next;
    event_t                 ev;
    logic                   valid_motion, active, ble_hold;
    logic                   settle_done, linger_done;
    logic [31:0]            load_raw, load_sat;

    assign valid_motion = (motion == MOTION_STATIONARY) || (motion == MOTION_ACTIVE);
    assign active       = (motion == MOTION_ACTIVE);
    assign ble_hold     = (cfg.link == LINK_BLE) && ble;

    // Timers count down on every tick, whatever the motion class
    assign settle_dec  = (settle_reg != '0) ? settle_reg - 1'b1 : settle_reg;
    assign linger_dec  = (linger_reg != '0) ? linger_reg - 1'b1 : linger_reg;
    assign settle_done = (settle_dec == '0);
    assign linger_done = (linger_dec == '0);

    assign load_raw = (cfg.linger != '0) ? 32'(cfg.linger) : 32'(cfg.settle_home);
    assign load_sat = (load_raw > LINGER_MAX) ? LINGER_MAX : load_raw;

    // Next state
    always_comb
    begin
        mode_next   = mode_reg;
        settle_next = settle_dec;
        linger_next = linger_dec;
        if (valid_motion)
        begin
            unique case (mode_reg)
                MS_INIT:
                begin
                    if (active)
                    begin
                        settle_next = cfg.settle_drive;
                        mode_next   = MS_WAIT_DRIVE;
                    end
                    else
                    begin
                        settle_next = cfg.settle_home;
                        mode_next   = MS_WAIT_HOME;
                    end
                end
                MS_WAIT_DRIVE:
                begin
                    if (!active)
                    begin
                        settle_next = cfg.settle_home;
                        mode_next   = MS_WAIT_HOME;
                    end
                    else if (settle_done)
                    begin
                        mode_next = MS_DRIVE;
                    end
                end
                MS_WAIT_HOME:
                begin
                    if (active)
                    begin
                        settle_next = cfg.settle_drive;
                        mode_next   = MS_WAIT_DRIVE;
                    end
                    else if (settle_done)
                    begin
                        mode_next = MS_HOME;
                    end
                end
                MS_DRIVE:
                begin
                    if (!active && !ble_hold)
                    begin
                        linger_next = load_sat[LINGER_BITS-1:0];
                        mode_next   = MS_LINGER;
                    end
                end
                MS_LINGER:
                begin
                    if (active || ble_hold)
                        mode_next = MS_DRIVE;
                    else if (linger_done)
                        mode_next = MS_HOME;
                end
                MS_HOME:
                begin
                    if (active)
                    begin
                        settle_next = cfg.settle_drive;
                        mode_next   = MS_WAIT_DRIVE;
                    end
                end
                default:
                    mode_next = MS_INIT;
            endcase
        end
    end

    // Flags and event follow the transition taken
    always_comb
    begin
        drive_next   = drive_reg;
        home_next    = home_reg;
        autopid_next = autopid_reg;
        ev           = EV_NONE;
        if (valid_motion)
        begin
            unique case (mode_reg)
                MS_WAIT_DRIVE:
                begin
                    if (active && settle_done)
                    begin
                        drive_next = 1'b1;
                        home_next  = 1'b0;
                        if (cfg.clr_autopid)
                            autopid_next = 1'b0;
                        ev = EV_ENTER_DRIVE;
                    end
                end
                MS_WAIT_HOME:
                begin
                    if (!active && settle_done)
                    begin
                        home_next  = 1'b1;
                        drive_next = 1'b0;
                        if (cfg.set_autopid)
                            autopid_next = 1'b1;
                        ev = EV_ENTER_HOME;
                    end
                end
                MS_LINGER:
                begin
                    if (!active && !ble_hold && linger_done)
                    begin
                        home_next  = 1'b1;
                        drive_next = 1'b0;
                        if (cfg.set_autopid)
                            autopid_next = 1'b1;
                        ev = EV_DRIVE_TO_HOME;
                    end
                end
                MS_HOME:
                begin
                    if (active)
                    begin
                        home_next = 1'b0;
                        ev        = EV_LEAVE_HOME;
                    end
                end
                default:
                    ev = EV_NONE;
            endcase
        end
    end

    assign res.mode    = mode_next;
    assign res.drive   = drive_next;
    assign res.home    = home_next;
    assign res.autopid = autopid_next;
    assign res.ev      = ev;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MS_INIT;
            settle_reg  <= '0;
            linger_reg  <= '0;
            drive_reg   <= 1'b0;
            home_reg    <= 1'b1;
            autopid_reg <= 1'b0;
        end
        else if (tick)
        begin
            mode_reg    <= mode_next;
            settle_reg  <= settle_next;
            linger_reg  <= linger_next;
            drive_reg   <= drive_next;
            home_reg    <= home_next;
            autopid_reg <= autopid_next;
        end
    end

endmodule

[rtl/motion_qualified_mode_switch_unit.sv]
`timescale 1ns / 1ps

// Home/drive mode selector: one request is one evaluation tick carrying the
// motion class and the BLE link flag, and yields one result with the mode,
// the three status flags and the transition event. A request is registered,
// evaluated against the state and its result registered; a new request is
// taken every cycle unless the output stalls, and the state update (two
// down-counters and the six-state machine) lands with the result. The settle
// and linger timers count ticks, not clock cycles. Registers must be written
// over the APB port while no request is in flight; the block does not check.

module motion_qualified_mode_switch_unit
    import mqms_pkg::*;
#(
    parameter int LINGER_BITS = LINGER_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            motion,
    input  logic                  ble_connected,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            mode,
    output logic                  drive_flag,
    output logic                  home_flag,
    output logic                  autopid_flag,
    output logic [2:0]            event_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t       cfg;
    res_t       res;
    res_t       res_reg;
    logic       in_valid_reg, in_valid_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] motion_reg;
    logic       ble_reg;
    logic       advance, accept, tick;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;
    assign tick     = in_valid_reg && advance;

    assign in_valid_next  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    mqms_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mqms_fsm #(
        .LINGER_BITS (LINGER_BITS)
    ) u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick),
        .motion (motion_reg),
        .ble    (ble_reg),
        .cfg    (cfg),
        .res    (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            motion_reg <= motion;
            ble_reg    <= ble_connected;
        end
        if (tick)
            res_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign mode         = res_reg.mode;
    assign drive_flag   = res_reg.drive;
    assign home_flag    = res_reg.home;
    assign autopid_flag = res_reg.autopid;
    assign event_res    = res_reg.ev;

endmodule

[bench/tb_motion_qualified_mode_switch_unit.sv]
`timescale 1ns / 1ps

module tb_motion_qualified_mode_switch_unit;

    import mqms_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          PRESS_CYCLES   = 300;
    localparam int          DRAIN_CYCLES   = 6;
    localparam logic [1:0]  MOTION_UNUSED  = 2'd3;
    localparam logic [1:0]  LINK_UNUSED    = 2'd3;
    localparam logic [2:0]  REG_SPARE_LO   = 3'd6;
    localparam logic [2:0]  REG_SPARE_HI   = 3'd7;

    class mode_scoreboard;
        logic [SETTLE_W-1:0]     settle_drive;
        logic [SETTLE_W-1:0]     settle_home;
        logic [LINGER_REG_W-1:0] linger_ticks;
        logic [1:0]              link;
        logic                    clr_autopid;
        logic                    set_autopid;

        mode_t                   st;
        logic [SETTLE_W-1:0]     settle_cnt;
        logic [63:0]             linger_cnt;
        logic                    drive_b;
        logic                    home_b;
        logic                    autopid_b;

        res_t                    pending_modes[$];
        int                      errors;
        int                      n_checked;

        function new();
            settle_drive = SETTLE_DRIVE_RST;
            settle_home  = SETTLE_HOME_RST;
            linger_ticks = LINGER_RST;
            link         = LINK_NONE;
            clr_autopid  = 1'b0;
            set_autopid  = 1'b0;
            st           = MS_INIT;
            settle_cnt   = '0;
            linger_cnt   = '0;
            drive_b      = 1'b0;
            home_b       = 1'b1;
            autopid_b    = 1'b0;
            errors       = 0;
            n_checked    = 0;
        endfunction

        task report(input string msg);
            errors++;
            $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        function void set_reg(input logic [2:0] idx, input logic [31:0] data);
            case (idx)
                REG_SETTLE_DRIVE: settle_drive = data[SETTLE_W-1:0];
                REG_SETTLE_HOME:  settle_home  = data[SETTLE_W-1:0];
                REG_LINGER:       linger_ticks = data[LINGER_REG_W-1:0];
                REG_DRIVE_LINK:   link         = data[1:0];
                REG_CLR_AUTOPID:  clr_autopid  = data[0];
                REG_SET_AUTOPID:  set_autopid  = data[0];
                default: ;
            endcase
        endfunction

        function logic [31:0] reg_value(input logic [2:0] idx);
            case (idx)
                REG_SETTLE_DRIVE: return 32'(settle_drive);
                REG_SETTLE_HOME:  return 32'(settle_home);
                REG_LINGER:       return 32'(linger_ticks);
                REG_DRIVE_LINK:   return 32'(link);
                REG_CLR_AUTOPID:  return 32'(clr_autopid);
                REG_SET_AUTOPID:  return 32'(set_autopid);
                default:          return '0;
            endcase
        endfunction

        // one accepted request: advance the mode machine, queue the expected result
        function void advance_mode(input logic [1:0] mot, input logic ble);
            logic        hold;
            logic        settle_done;
            logic        linger_done;
            logic        active;
            logic [63:0] load;
            event_t      ev;
            res_t        r;

            hold = (link == LINK_BLE) && ble;
            ev   = EV_NONE;
            if (settle_cnt != 0) settle_cnt--;
            if (linger_cnt != 0) linger_cnt--;
            settle_done = (settle_cnt == 0);
            linger_done = (linger_cnt == 0);

            if (mot == MOTION_STATIONARY || mot == MOTION_ACTIVE) begin
                active = (mot == MOTION_ACTIVE);
                case (st)
                    MS_INIT:
                    begin
                        settle_cnt = active ? settle_drive : settle_home;
                        st         = active ? MS_WAIT_DRIVE : MS_WAIT_HOME;
                    end
                    MS_WAIT_DRIVE:
                    begin
                        if (!active) begin
                            settle_cnt = settle_home;
                            st         = MS_WAIT_HOME;
                        end else if (settle_done) begin
                            drive_b = 1'b1;
                            home_b  = 1'b0;
                            if (clr_autopid) autopid_b = 1'b0;
                            ev = EV_ENTER_DRIVE;
                            st = MS_DRIVE;
                        end
                    end
                    MS_WAIT_HOME:
                    begin
                        if (active) begin
                            settle_cnt = settle_drive;
                            st         = MS_WAIT_DRIVE;
                        end else if (settle_done) begin
                            home_b  = 1'b1;
                            drive_b = 1'b0;
                            if (set_autopid) autopid_b = 1'b1;
                            ev = EV_ENTER_HOME;
                            st = MS_HOME;
                        end
                    end
                    MS_DRIVE:
                    begin
                        if (!active && !hold) begin
                            load = (linger_ticks != 0) ? 64'(linger_ticks) : 64'(settle_home);
                            if (load > (64'd1 << LINGER_BITS_DEF) - 1)
                                load = (64'd1 << LINGER_BITS_DEF) - 1;
                            linger_cnt = load;
                            st         = MS_LINGER;
                        end
                    end
                    MS_LINGER:
                    begin
                        if (active || hold) begin
                            st = MS_DRIVE;
                        end else if (linger_done) begin
                            home_b  = 1'b1;
                            drive_b = 1'b0;
                            if (set_autopid) autopid_b = 1'b1;
                            ev = EV_DRIVE_TO_HOME;
                            st = MS_HOME;
                        end
                    end
                    MS_HOME:
                    begin
                        if (active) begin
                            home_b     = 1'b0;
                            ev         = EV_LEAVE_HOME;
                            settle_cnt = settle_drive;
                            st         = MS_WAIT_DRIVE;
                        end
                    end
                    default: st = MS_INIT;
                endcase
            end

            r.mode    = st;
            r.drive   = drive_b;
            r.home    = home_b;
            r.autopid = autopid_b;
            r.ev      = ev;
            pending_modes.push_back(r);
        endfunction

        task check_result(input res_t got);
            res_t w;
            if (pending_modes.size() == 0) begin
                report($sformatf("result %0d arrived with nothing pending", n_checked));
                n_checked++;
                return;
            end
            w = pending_modes.pop_front();
            if (got.mode !== w.mode)
                report($sformatf("result %0d mode %0d, expected %0d",
                                 n_checked, got.mode, w.mode));
            if (got.drive !== w.drive)
                report($sformatf("result %0d drive_flag %b, expected %b",
                                 n_checked, got.drive, w.drive));
            if (got.home !== w.home)
                report($sformatf("result %0d home_flag %b, expected %b",
                                 n_checked, got.home, w.home));
            if (got.autopid !== w.autopid)
                report($sformatf("result %0d autopid_flag %b, expected %b",
                                 n_checked, got.autopid, w.autopid));
            if (got.ev !== w.ev)
                report($sformatf("result %0d event_res %0d, expected %0d",
                                 n_checked, got.ev, w.ev));
            n_checked++;
        endtask

        function int pending();
            return pending_modes.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            motion;
    logic                  ble_connected;
    logic                  out_valid;
    logic                  out_stall;
    logic [2:0]            mode;
    logic                  drive_flag;
    logic                  home_flag;
    logic                  autopid_flag;
    logic [2:0]            event_res;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    mode_scoreboard sb = new();

    bit tx_quiet;
    bit rx_quiet;
    bit press_req;
    int idle_run;

    motion_qualified_mode_switch_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .motion        (motion),
        .ble_connected (ble_connected),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .mode          (mode),
        .drive_flag    (drive_flag),
        .home_flag     (home_flag),
        .autopid_flag  (autopid_flag),
        .event_res     (event_res),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // requests and results are both seen here, request first
    always @(posedge clk)
    begin : monitor
        res_t got;
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.advance_mode(motion, ble_connected);
            if (out_valid && !out_stall) begin
                got = {mode, drive_flag, home_flag, autopid_flag, event_res};
                sb.check_result(got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stall before each result, one long hold on request
    initial
    begin
        int n;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            if (press_req) begin
                n         = PRESS_CYCLES;
                press_req = 1'b0;
            end else begin
                n = rx_quiet ? 0 : $urandom_range(0, 19);
            end
            if (n != 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic apb_write(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (rd !== sb.reg_value(idx))
            sb.report($sformatf("register %0d reads %0h, expected %0h",
                                idx, rd, sb.reg_value(idx)));
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        apb_write(idx, data);
        sb.set_reg(idx, data);
        check_reg(idx);
    endtask

    // upper bits beyond each register's width carry junk and must be dropped
    task automatic apply_settings(input logic [15:0] sd, input logic [15:0] sh,
                                  input logic [23:0] lg, input logic [1:0] lk,
                                  input logic clr, input logic set);
        cfg_write(REG_SETTLE_DRIVE, {16'($urandom), sd});
        cfg_write(REG_SETTLE_HOME,  {16'($urandom), sh});
        cfg_write(REG_LINGER,       {8'($urandom), lg});
        cfg_write(REG_DRIVE_LINK,   {30'($urandom), lk});
        cfg_write(REG_CLR_AUTOPID,  {31'($urandom), clr});
        cfg_write(REG_SET_AUTOPID,  {31'($urandom), set});
        if ($urandom_range(0, 2) == 0)
            apply_spare();
    endtask

    task automatic apply_spare();
        apb_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
    endtask

    task automatic send_tick(input logic [1:0] mot, input logic ble);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        motion        <= mot;
        ble_connected <= ble;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_settle();
        return ($urandom_range(0, 4) == 0) ? 16'($urandom_range(9, 40))
                                           : 16'($urandom_range(0, 8));
    endfunction

    // runs of one motion class let the settle timers expire; short invalid bursts as noise
    task automatic run_motion(input int n_valid);
        int         done;
        int         run;
        logic [1:0] cls;
        logic       ble;
        done = 0;
        while (done < n_valid) begin
            if ($urandom_range(0, 9) == 0) begin
                cls = $urandom_range(0, 1) ? MOTION_INVALID : MOTION_UNUSED;
                run = $urandom_range(1, 3);
            end else begin
                cls = $urandom_range(0, 1) ? MOTION_ACTIVE : MOTION_STATIONARY;
                run = $urandom_range(1, 12);
            end
            ble = 1'($urandom_range(0, 1));
            repeat (run) begin
                send_tick(cls, ($urandom_range(0, 7) == 0) ? ~ble : ble);
                if (cls == MOTION_ACTIVE || cls == MOTION_STATIONARY)
                    done++;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        motion        = MOTION_INVALID;
        ble_connected = 1'b0;
        out_stall     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tx_quiet      = 1'b0;
        rx_quiet      = 1'b0;
        press_req     = 1'b0;
        idle_run      = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < 6; i++)
            check_reg(3'(i));

        // reset settings: invalid codes, then leave init and switch between the wait states
        send_tick(MOTION_INVALID, 1'b0);
        send_tick(MOTION_UNUSED, 1'b1);
        send_tick(MOTION_STATIONARY, 1'b0);
        send_tick(MOTION_ACTIVE, 1'b1);
        send_tick(MOTION_STATIONARY, 1'b1);
        send_tick(MOTION_ACTIVE, 1'b0);
        wait_drained();

        // short timers, BLE link: every event, BLE hold, linger and its expiry
        apply_settings(16'd1, 16'd2, 24'd0, LINK_BLE, 1'b1, 1'b1);
        send_tick(MOTION_STATIONARY, 1'b0);
        send_tick(MOTION_STATIONARY, 1'b0);
        send_tick(MOTION_STATIONARY, 1'b0);
        send_tick(MOTION_STATIONARY, 1'b0);
        send_tick(MOTION_ACTIVE, 1'b0);
        send_tick(MOTION_ACTIVE, 1'b0);
        send_tick(MOTION_STATIONARY, 1'b1);
        send_tick(MOTION_INVALID, 1'b0);
        send_tick(MOTION_STATIONARY, 1'b0);
        send_tick(MOTION_ACTIVE, 1'b0);
        send_tick(MOTION_STATIONARY, 1'b0);
        send_tick(MOTION_UNUSED, 1'b0);
        send_tick(MOTION_STATIONARY, 1'b1);
        send_tick(MOTION_STATIONARY, 1'b0);
        send_tick(MOTION_STATIONARY, 1'b0);
        send_tick(MOTION_STATIONARY, 1'b0);
        send_tick(MOTION_ACTIVE, 1'b1);
        send_tick(MOTION_STATIONARY, 1'b1);
        wait_drained();

        apply_settings(16'hFFFF, 16'hFFFF, 24'hFFFFFF, LINK_UNUSED, 1'b1, 1'b1);
        run_motion(60);
        wait_drained();

        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        apply_settings(16'd0, 16'd0, 24'd0, LINK_NONE, 1'b0, 1'b0);
        run_motion(100);
        wait_drained();

        // back-pressure: results held off while requests keep coming
        rx_quiet = 1'b0;
        apply_settings(pick_settle(), pick_settle(), 24'($urandom_range(0, 10)),
                       LINK_BLE, 1'b1, 1'b0);
        press_req = 1'b1;
        run_motion(150);
        wait_drained();

        for (int ph = 0; ph < 8; ph++) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            apply_settings(pick_settle(), pick_settle(),
                           ($urandom_range(0, 2) == 0) ? 24'd0 : 24'($urandom_range(1, 12)),
                           2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
            run_motion(90);
            wait_drained();
        end

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
rtl/mqms_pkg.sv
rtl/mqms_cfg.sv
rtl/mqms_fsm.sv
rtl/motion_qualified_mode_switch_unit.sv
bench/tb_motion_qualified_mode_switch_unit.sv
